/* hdl/cbpg_pkg.sv */
// ----------------------------------------------------------------------------
// cbpg_pkg
// Shared types and constants of the cubic Bezier point generator: widths,
// register indexes, sequencer states and the structs between the stages.
// ----------------------------------------------------------------------------
package cbpg_pkg;

    localparam int MAX_POINTS_DEF = 64;

    localparam int COORD_W = 16;   // Q8.8 coordinate
    localparam int PC_W    = 7;    // point_count register
    localparam int TI_W    = 17;   // t_increment register, Q0.16
    localparam int T_W     = 17;   // curve parameter, Q0.16, up to 1.0
    localparam int CFG_W   = 17;   // widest register
    localparam int W_W     = 49;   // Bernstein weight, Q0.48, up to 1.0
    localparam int SQ_W    = 33;   // t*t, u*u, t*u in Q0.32

    localparam logic [T_W-1:0]  T_ONE      = 17'h10000;
    localparam logic [PC_W-1:0] PC_RESET   = 7'd64;
    localparam logic [TI_W-1:0] TI_RESET   = 17'd1024;
    localparam logic [67:0]     ROUND_HALF = 68'h0_0000_8000_0000_0000;

    // register indexes of the configuration port
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_POINT_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_T_INCREMENT = 1'b1;

    typedef enum logic {
        S_IDLE,
        S_RUN
    } t_seq_state;

    // one curve point entering the weight pipeline
    typedef struct packed {
        logic           valid;
        logic           last;
        logic [T_W-1:0] t;
    } t_issue;

    // Bernstein weights of one point, shared by all lanes
    typedef struct packed {
        logic           valid;
        logic           last;
        logic [W_W-1:0] w0;
        logic [W_W-1:0] w1;
        logic [W_W-1:0] w2;
        logic [W_W-1:0] w3;
    } t_wgt;

    // result of one coordinate lane
    typedef struct packed {
        logic                      valid;
        logic                      last;
        logic signed [COORD_W-1:0] coord;
    } t_lane;

endpackage

/* hdl/cbpg_curve_if.sv */
// ----------------------------------------------------------------------------
// cbpg_curve_if
// Curve request channel: four 3D control points in signed Q8.8.
// ----------------------------------------------------------------------------
interface cbpg_curve_if
    import cbpg_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] p0_x;
    logic signed [COORD_W-1:0] p0_y;
    logic signed [COORD_W-1:0] p0_z;
    logic signed [COORD_W-1:0] p1_x;
    logic signed [COORD_W-1:0] p1_y;
    logic signed [COORD_W-1:0] p1_z;
    logic signed [COORD_W-1:0] p2_x;
    logic signed [COORD_W-1:0] p2_y;
    logic signed [COORD_W-1:0] p2_z;
    logic signed [COORD_W-1:0] p3_x;
    logic signed [COORD_W-1:0] p3_y;
    logic signed [COORD_W-1:0] p3_z;

    modport source (
        output valid, p0_x, p0_y, p0_z, p1_x, p1_y, p1_z,
               p2_x, p2_y, p2_z, p3_x, p3_y, p3_z,
        input  ready
    );
    modport sink (
        input  valid, p0_x, p0_y, p0_z, p1_x, p1_y, p1_z,
               p2_x, p2_y, p2_z, p3_x, p3_y, p3_z,
        output ready
    );
endinterface

/* hdl/cbpg_point_if.sv */
// ----------------------------------------------------------------------------
// cbpg_point_if
// Curve point channel: one point in signed Q8.8 and an end-of-curve flag.
// ----------------------------------------------------------------------------
interface cbpg_point_if
    import cbpg_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] point_z;
    logic                      last_point;

    modport source (
        output valid, point_x, point_y, point_z, last_point,
        input  ready
    );
    modport sink (
        input  valid, point_x, point_y, point_z, last_point,
        output ready
    );
endinterface

/* hdl/cubic_bezier_point_generator_core.sv */
// Path: the first point of a curve passes the sequencer state register, the weight stages, the
// lane stages and the output register. Throughput: one point per cycle while the output is not
// stalled; the 6-stage weight and lane pipeline drains before the next request is accepted.
// Output backpressure stalls the whole pipeline; the output register holds a point.
// Reset (synchronous, active low) clears the sequencer and valid bits and sets
// point_count to 64 and t_increment to 1024; control coordinates are not reset.
// ----------------------------------------------------------------------------
// cubic_bezier_point_generator_core
// Cubic Bezier point generator: per curve request, emits point_count points
// at t = i * t_increment (saturating at 1.0), x/y/z evaluated in parallel lanes.
// ----------------------------------------------------------------------------
module cubic_bezier_point_generator_core
    import cbpg_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    cbpg_curve_if.sink           i_curve,
    cbpg_point_if.source         o_point
);
    logic [PC_W-1:0] r_point_count;
    logic [TI_W-1:0] r_t_increment;

    logic signed [COORD_W-1:0] r_p0_x, r_p0_y, r_p0_z;
    logic signed [COORD_W-1:0] r_p1_x, r_p1_y, r_p1_z;
    logic signed [COORD_W-1:0] r_p2_x, r_p2_y, r_p2_z;
    logic signed [COORD_W-1:0] r_p3_x, r_p3_y, r_p3_z;

    logic   seq_idle;
    logic   advance;
    logic   start;
    logic   wgt_busy;
    logic   lane_x_busy, lane_y_busy, lane_z_busy;
    t_issue issue;
    t_wgt   wgt;
    t_lane  lane_x, lane_y, lane_z;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_point_count <= PC_RESET;
            r_t_increment <= TI_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_POINT_COUNT: r_point_count <= i_cfg_data[PC_W-1:0];
                REG_T_INCREMENT: r_t_increment <= i_cfg_data[TI_W-1:0];
                default: r_point_count <= r_point_count;
            endcase
        end
    end

    // take a new curve once the previous one has left the lanes
    assign i_curve.ready = seq_idle && !wgt_busy && !lane_x_busy && !lane_y_busy
                           && !lane_z_busy;
    assign start = i_curve.valid && i_curve.ready;

    // capture the control points
    always_ff @(posedge i_clk) begin
        if (start) begin
            r_p0_x <= i_curve.p0_x;
            r_p0_y <= i_curve.p0_y;
            r_p0_z <= i_curve.p0_z;
            r_p1_x <= i_curve.p1_x;
            r_p1_y <= i_curve.p1_y;
            r_p1_z <= i_curve.p1_z;
            r_p2_x <= i_curve.p2_x;
            r_p2_y <= i_curve.p2_y;
            r_p2_z <= i_curve.p2_z;
            r_p3_x <= i_curve.p3_x;
            r_p3_y <= i_curve.p3_y;
            r_p3_z <= i_curve.p3_z;
        end
    end

    cbpg_sequencer #(
        .MAX_POINTS (MAX_POINTS)
    ) u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_point_count (r_point_count),
        .i_t_increment (r_t_increment),
        .i_advance     (advance),
        .o_idle        (seq_idle),
        .o_issue       (issue)
    );

    cbpg_weights u_wgt (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_issue   (issue),
        .o_wgt     (wgt),
        .o_busy    (wgt_busy)
    );

    cbpg_lane u_lane_x (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_wgt     (wgt),
        .i_c0      (r_p0_x),
        .i_c1      (r_p1_x),
        .i_c2      (r_p2_x),
        .i_c3      (r_p3_x),
        .o_lane    (lane_x),
        .o_busy    (lane_x_busy)
    );

    cbpg_lane u_lane_y (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_wgt     (wgt),
        .i_c0      (r_p0_y),
        .i_c1      (r_p1_y),
        .i_c2      (r_p2_y),
        .i_c3      (r_p3_y),
        .o_lane    (lane_y),
        .o_busy    (lane_y_busy)
    );

    cbpg_lane u_lane_z (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_wgt     (wgt),
        .i_c0      (r_p0_z),
        .i_c1      (r_p1_z),
        .i_c2      (r_p2_z),
        .i_c3      (r_p3_z),
        .o_lane    (lane_z),
        .o_busy    (lane_z_busy)
    );

    cbpg_merge u_merge (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_lane_x  (lane_x),
        .i_lane_y  (lane_y),
        .i_lane_z  (lane_z),
        .o_advance (advance),
        .o_point   (o_point)
    );

    a_one_curve_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |=> !i_curve.ready)
        else $error("new curve taken while one is in progress");

    a_no_issue_while_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        seq_idle |-> !issue.valid)
        else $error("point issued outside a curve");

endmodule

/* hdl/cbpg_sequencer.sv */
// ----------------------------------------------------------------------------
// cbpg_sequencer
// Walks the point index of one curve and steps the curve parameter t by
// t_increment per point, saturating at 1.0. Issues one point per advance.
// ----------------------------------------------------------------------------
module cbpg_sequencer
    import cbpg_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [PC_W-1:0] i_point_count,
    input  logic [TI_W-1:0] i_t_increment,
    input  logic            i_advance,
    output logic            o_idle,
    output t_issue          o_issue
);
    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam logic [PC_W-1:0] MAX_PC = PC_W'(MAX_POINTS);

    t_seq_state     r_state, n_state;
    logic [CNT_W-1:0] r_index;
    logic [CNT_W-1:0] r_count;
    logic [T_W-1:0]   r_t;
    logic [PC_W-1:0]  clamp_count;
    logic [T_W:0]     t_sum;
    logic [T_W-1:0]   t_step;
    logic             is_last;
    logic             issue;

    // clamp the requested count to 1..MAX_POINTS
    always_comb begin
        priority if (i_point_count == '0) begin
            clamp_count = PC_W'(1);
        end else if (i_point_count > MAX_PC) begin
            clamp_count = MAX_PC;
        end else begin
            clamp_count = i_point_count;
        end
    end

    // saturating step of t
    assign t_sum  = {1'b0, r_t} + {1'b0, i_t_increment};
    assign t_step = (t_sum > {1'b0, T_ONE}) ? T_ONE : t_sum[T_W-1:0];

    assign is_last = ((r_index + CNT_W'(1)) == r_count);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (i_advance && is_last) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_idle        = 1'b0;
        o_issue.valid = 1'b0;
        o_issue.last  = is_last;
        o_issue.t     = r_t;
        unique case (r_state)
            S_IDLE: o_idle = 1'b1;
            S_RUN:  o_issue.valid = 1'b1;
            default: o_idle = 1'b0;
        endcase
    end

    assign issue = o_issue.valid && i_advance;

    // hold index, count and t
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_index <= '0;
            r_count <= '0;
            r_t     <= '0;
        end else begin
            r_state <= n_state;
            if (i_start && r_state == S_IDLE) begin
                r_count <= CNT_W'(clamp_count);
                r_index <= '0;
                r_t     <= '0;
            end else if (issue) begin
                if (is_last) begin
                    r_index <= '0;
                    r_t     <= '0;
                end else begin
                    r_index <= r_index + CNT_W'(1);
                    r_t     <= t_step;
                end
            end
        end
    end

    a_index_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_RUN |-> r_index < r_count)
        else $error("point index beyond point count");

    a_t_saturated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_t <= T_ONE)
        else $error("curve parameter above one");

    a_t_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_IDLE |-> r_t == '0 && r_index == '0)
        else $error("t or index not cleared between curves");

endmodule

/* hdl/cbpg_weights.sv */
// ----------------------------------------------------------------------------
// cbpg_weights
// Three-stage pipeline from t to the four cubic Bernstein weights in Q0.48:
// u^3, 3u^2t, 3ut^2, t^3 with u = 1 - t. Shared by the coordinate lanes.
// ----------------------------------------------------------------------------
module cbpg_weights
    import cbpg_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_advance,
    input  t_issue i_issue,
    output t_wgt   o_wgt,
    output logic   o_busy
);
    logic [T_W-1:0]   u_in;
    logic [2*T_W-1:0] uu_full, tt_full;

    // stage 1: squares
    logic             r_v1, r_l1;
    logic [T_W-1:0]   r_t1, r_u1;
    logic [SQ_W-1:0]  r_uu1, r_tt1;

    // stage 2: cubes and mixed terms
    logic                  r_v2, r_l2;
    logic [W_W-1:0]        r_w0_2, r_w3_2, r_a1_2, r_a2_2;
    logic [SQ_W+T_W-1:0]   uuu_full, ttt_full, uut_full, ttu_full;

    // stage 3: scale mixed terms by three
    logic             r_v3, r_l3;
    logic [W_W-1:0]   r_w0_3, r_w1_3, r_w2_3, r_w3_3;
    logic [W_W:0]     w1_full, w2_full;

    assign u_in    = T_ONE - i_issue.t;
    assign uu_full = {{T_W{1'b0}}, u_in} * {{T_W{1'b0}}, u_in};
    assign tt_full = {{T_W{1'b0}}, i_issue.t} * {{T_W{1'b0}}, i_issue.t};

    assign uuu_full = {{T_W{1'b0}}, r_uu1} * {{SQ_W{1'b0}}, r_u1};
    assign ttt_full = {{T_W{1'b0}}, r_tt1} * {{SQ_W{1'b0}}, r_t1};
    assign uut_full = {{T_W{1'b0}}, r_uu1} * {{SQ_W{1'b0}}, r_t1};
    assign ttu_full = {{T_W{1'b0}}, r_tt1} * {{SQ_W{1'b0}}, r_u1};

    assign w1_full = {r_a1_2, 1'b0} + {1'b0, r_a1_2};
    assign w2_full = {r_a2_2, 1'b0} + {1'b0, r_a2_2};

    // advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_advance) begin
            r_v1 <= i_issue.valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // advance payload
    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_l1   <= i_issue.last;
            r_t1   <= i_issue.t;
            r_u1   <= u_in;
            r_uu1  <= uu_full[SQ_W-1:0];
            r_tt1  <= tt_full[SQ_W-1:0];

            r_l2   <= r_l1;
            r_w0_2 <= uuu_full[W_W-1:0];
            r_w3_2 <= ttt_full[W_W-1:0];
            r_a1_2 <= uut_full[W_W-1:0];
            r_a2_2 <= ttu_full[W_W-1:0];

            r_l3   <= r_l2;
            r_w0_3 <= r_w0_2;
            r_w1_3 <= w1_full[W_W-1:0];
            r_w2_3 <= w2_full[W_W-1:0];
            r_w3_3 <= r_w3_2;
        end
    end

    assign o_wgt.valid = r_v3;
    assign o_wgt.last  = r_l3;
    assign o_wgt.w0    = r_w0_3;
    assign o_wgt.w1    = r_w1_3;
    assign o_wgt.w2    = r_w2_3;
    assign o_wgt.w3    = r_w3_3;
    assign o_busy      = r_v1 || r_v2 || r_v3;

    // the weights of (u + t)^3 always add up to exactly one
    a_partition_of_unity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 |-> ({2'b0, r_w0_3} + {2'b0, r_w1_3} + {2'b0, r_w2_3} + {2'b0, r_w3_3})
                 == {3'b001, {(W_W-1){1'b0}}})
        else $error("Bernstein weights do not sum to one");

endmodule

/* hdl/cbpg_lane.sv */
// ----------------------------------------------------------------------------
// cbpg_lane
// One coordinate lane: weighted sum of four control coordinates over three
// stages (products, pair sums, final sum with round half up to Q8.8).
// ----------------------------------------------------------------------------
module cbpg_lane
    import cbpg_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_advance,
    input  t_wgt                      i_wgt,
    input  logic signed [COORD_W-1:0] i_c0,
    input  logic signed [COORD_W-1:0] i_c1,
    input  logic signed [COORD_W-1:0] i_c2,
    input  logic signed [COORD_W-1:0] i_c3,
    output t_lane                     o_lane,
    output logic                      o_busy
);
    localparam int P_W = W_W + 1 + COORD_W;   // signed product
    localparam int S_W = P_W + 1;             // pair sum
    localparam int F_W = S_W + 1;             // final sum

    logic signed [P_W-1:0] n_p0, n_p1, n_p2, n_p3;
    logic signed [P_W-1:0] r_p0, r_p1, r_p2, r_p3;
    logic signed [S_W-1:0] r_s01, r_s23;
    logic signed [F_W-1:0] total;
    logic signed [COORD_W-1:0] r_coord;
    logic                  r_v1, r_v2, r_v3;
    logic                  r_l1, r_l2, r_l3;

    // weight times coordinate, weight as a positive signed value
    assign n_p0 = $signed({1'b0, i_wgt.w0}) * i_c0;
    assign n_p1 = $signed({1'b0, i_wgt.w1}) * i_c1;
    assign n_p2 = $signed({1'b0, i_wgt.w2}) * i_c2;
    assign n_p3 = $signed({1'b0, i_wgt.w3}) * i_c3;

    // add half an output step, then drop the 48 fraction bits below Q8.8
    assign total = F_W'(r_s01) + F_W'(r_s23) + $signed(ROUND_HALF);

    // advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_advance) begin
            r_v1 <= i_wgt.valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // advance payload
    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_l1    <= i_wgt.last;
            r_p0    <= n_p0;
            r_p1    <= n_p1;
            r_p2    <= n_p2;
            r_p3    <= n_p3;
            r_l2    <= r_l1;
            r_s01   <= S_W'(r_p0) + S_W'(r_p1);
            r_s23   <= S_W'(r_p2) + S_W'(r_p3);
            r_l3    <= r_l2;
            r_coord <= total[63:48];
        end
    end

    assign o_lane.valid = r_v3;
    assign o_lane.last  = r_l3;
    assign o_lane.coord = r_coord;
    assign o_busy       = r_v1 || r_v2 || r_v3;

endmodule

/* hdl/cbpg_merge.sv */
// ----------------------------------------------------------------------------
// cbpg_merge
// Joins the x, y and z lanes into one curve point and holds it in the output
// register; the pipeline moves whenever that register is free or taken.
// ----------------------------------------------------------------------------
module cbpg_merge
    import cbpg_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_lane i_lane_x,
    input  t_lane i_lane_y,
    input  t_lane i_lane_z,
    output logic  o_advance,
    cbpg_point_if.source o_point
);
    logic                      r_valid;
    logic                      r_last;
    logic signed [COORD_W-1:0] r_x, r_y, r_z;

    assign o_advance = !r_valid || o_point.ready;

    // hold the output transaction until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_advance) begin
            r_valid <= i_lane_x.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance && i_lane_x.valid) begin
            r_x    <= i_lane_x.coord;
            r_y    <= i_lane_y.coord;
            r_z    <= i_lane_z.coord;
            r_last <= i_lane_x.last;
        end
    end

    assign o_point.valid      = r_valid;
    assign o_point.point_x    = r_x;
    assign o_point.point_y    = r_y;
    assign o_point.point_z    = r_z;
    assign o_point.last_point = r_last;

    a_lanes_in_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_lane_x.valid == i_lane_y.valid && i_lane_x.valid == i_lane_z.valid)
        else $error("coordinate lanes out of step");

    a_lanes_same_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_lane_x.valid |-> i_lane_x.last == i_lane_y.last && i_lane_x.last == i_lane_z.last)
        else $error("coordinate lanes disagree on last point");

endmodule

/* tb/cubic_bezier_point_generator_core_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cubic_bezier_point_generator_core_tb
// Self-checking bench for the cubic Bezier point generator. A queue-fed
// driver offers curve requests, a monitor checks every emitted point against
// an exact Bernstein-sum predictor, and the register settings sweep the
// clamped point counts and saturating parameter steps.
// ----------------------------------------------------------------------------
module cubic_bezier_point_generator_core_tb;
    import cbpg_pkg::*;

    localparam int RANDOM_PHASES = 15;
    localparam int PHASE_ITEMS   = 25;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 16;
    localparam int WDOG_LIMIT    = 4000;
    localparam int PRINT_CAP     = 40;

    // twelve control coordinates in request order: p0 xyz, p1 xyz, p2 xyz, p3 xyz
    typedef logic [11:0][COORD_W-1:0] t_curve;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
        logic               last;
    } t_point;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0] i_cfg_data;

    cbpg_curve_if crv_if ();
    cbpg_point_if pt_if ();

    cubic_bezier_point_generator_core #(
        .MAX_POINTS (MAX_POINTS_DEF)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_curve    (crv_if),
        .o_point    (pt_if)
    );

    t_curve          pending_curves[$];
    t_point          expected_points[$];
    logic [PC_W-1:0] count_setting;
    logic [TI_W-1:0] step_setting;

    bit     tx_busy;
    t_curve tx_curve;
    int     tx_gap;
    bit     gaps_on;
    bit     stalls_on;
    int     hold_req;
    int     hold_served;
    int     rx_stall;
    int     errors;
    int     curves_sent;
    int     points_checked;
    int     settings_used;
    int     idle_cycles;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Exact Bernstein sum at Q0.16 t, rounded half up from Q8.56 to Q8.8
    function automatic logic [COORD_W-1:0] bernstein_coord(
        logic [T_W-1:0] t, logic [COORD_W-1:0] a, logic [COORD_W-1:0] b,
        logic [COORD_W-1:0] c, logic [COORD_W-1:0] d);
        logic signed [79:0] tt;
        logic signed [79:0] uu;
        logic signed [79:0] sa;
        logic signed [79:0] sb;
        logic signed [79:0] sc;
        logic signed [79:0] sd;
        logic signed [79:0] acc;
        tt  = {63'd0, t};
        uu  = {63'd0, T_ONE - t};
        sa  = $signed(a);
        sb  = $signed(b);
        sc  = $signed(c);
        sd  = $signed(d);
        acc = uu * uu * uu * sa + 3 * uu * uu * tt * sb
            + 3 * uu * tt * tt * sc + tt * tt * tt * sd;
        acc = (acc + (80'sd1 <<< 47)) >>> 48;
        return acc[COORD_W-1:0];
    endfunction

    // Append one request to the driver's queue
    function automatic void queue_curve(t_curve c);
        pending_curves = {pending_curves, c};
    endfunction

    // Queue every point one request produces under the current settings
    function automatic void expand_curve(t_curve c);
        int             n;
        logic [23:0]    prod;
        logic [T_W-1:0] t;
        t_point         p;
        n = int'(count_setting);
        if (n == 0) n = 1;
        if (n > MAX_POINTS_DEF) n = MAX_POINTS_DEF;
        for (int i = 0; i < n; i++) begin
            prod   = 24'(i * step_setting);
            t      = (prod > 24'd65536) ? T_ONE : prod[T_W-1:0];
            p.x    = bernstein_coord(t, c[0], c[3], c[6], c[9]);
            p.y    = bernstein_coord(t, c[1], c[4], c[7], c[10]);
            p.z    = bernstein_coord(t, c[2], c[5], c[8], c[11]);
            p.last = (i == n - 1);
            expected_points = {expected_points, p};
        end
    endfunction

    // Same value on all three axes of each control point
    function automatic t_curve make_curve(logic [15:0] v0, logic [15:0] v1,
                                          logic [15:0] v2, logic [15:0] v3);
        t_curve c;
        for (int k = 0; k < 3; k++) begin
            c[k]     = v0;
            c[3 + k] = v1;
            c[6 + k] = v2;
            c[9 + k] = v3;
        end
        return c;
    endfunction

    function automatic t_curve rand_curve();
        t_curve c;
        int     mode;
        logic [15:0] corner;
        mode = $urandom_range(0, 9);
        for (int k = 0; k < 12; k++) begin
            case ($urandom_range(0, 3))
                0:       corner = 16'h8000;
                1:       corner = 16'h7FFF;
                2:       corner = 16'hFFFF;
                default: corner = 16'h0000;
            endcase
            if (mode <= 5)      c[k] = 16'($urandom());
            else if (mode <= 7) c[k] = 16'($urandom_range(0, 1023) - 512);
            else                c[k] = corner;
        end
        // degenerate curve: every control point at one spot
        if (mode == 9) c = make_curve(c[0], c[0], c[0], c[0]);
        return c;
    endfunction

    function automatic int pick_gap(bit on, int lo, int hi);
        int r;
        r = $urandom_range(0, 99);
        if (!on || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(lo, hi);
    endfunction

    task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
        if (errors < PRINT_CAP)
            $display("[%0t] point %0d %s: got %h expected %h",
                     $realtime, points_checked, what, got, want);
        errors++;
    endtask

    // Driver: offer queued requests, predict on each accepted transaction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            crv_if.valid <= 1'b0;
            tx_busy = 1'b0;
            tx_gap  = 0;
        end else begin
            if (tx_busy && crv_if.ready) begin
                expand_curve(tx_curve);
                curves_sent++;
                tx_busy = 1'b0;
                tx_gap  = pick_gap(gaps_on, 10, 40);
            end
            if (!tx_busy) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                end else if (pending_curves.size() > 0) begin
                    tx_curve = pending_curves.pop_front();
                    tx_busy  = 1'b1;
                    crv_if.p0_x <= tx_curve[0];
                    crv_if.p0_y <= tx_curve[1];
                    crv_if.p0_z <= tx_curve[2];
                    crv_if.p1_x <= tx_curve[3];
                    crv_if.p1_y <= tx_curve[4];
                    crv_if.p1_z <= tx_curve[5];
                    crv_if.p2_x <= tx_curve[6];
                    crv_if.p2_y <= tx_curve[7];
                    crv_if.p2_z <= tx_curve[8];
                    crv_if.p3_x <= tx_curve[9];
                    crv_if.p3_y <= tx_curve[10];
                    crv_if.p3_z <= tx_curve[11];
                end
            end
            crv_if.valid <= tx_busy;
        end
    end

    // Monitor: check each accepted point, then pick the next ready level
    always @(posedge i_clk) begin
        t_point want;
        if (!i_rst_n) begin
            pt_if.ready <= 1'b0;
            rx_stall = 0;
        end else begin
            if (pt_if.valid && pt_if.ready) begin
                if (expected_points.size() == 0) begin
                    report_mismatch("unexpected", pt_if.point_x, 16'h0);
                end else begin
                    want = expected_points.pop_front();
                    if (pt_if.point_x !== want.x)
                        report_mismatch("point_x", pt_if.point_x, want.x);
                    if (pt_if.point_y !== want.y)
                        report_mismatch("point_y", pt_if.point_y, want.y);
                    if (pt_if.point_z !== want.z)
                        report_mismatch("point_z", pt_if.point_z, want.z);
                    if (pt_if.last_point !== want.last)
                        report_mismatch("last_point", {15'd0, pt_if.last_point},
                                        {15'd0, want.last});
                end
                points_checked++;
            end
            if (hold_served != hold_req) begin
                hold_served = hold_req;
                rx_stall    = HOLD_CYCLES;
            end else if (rx_stall > 0) begin
                rx_stall--;
            end else begin
                rx_stall = pick_gap(stalls_on, 8, 30);
            end
            pt_if.ready <= (rx_stall == 0);
        end
    end

    // Watchdog: end the run if nothing moves for too long
    always @(posedge i_clk) begin
        if ((crv_if.valid && crv_if.ready) || (pt_if.valid && pt_if.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WDOG_LIMIT) begin
            $display("[%0t] timeout: no transaction for %0d cycles", $realtime, idle_cycles);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Registers are only written while the block is idle
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        if (idx == REG_POINT_COUNT) count_setting = data[PC_W-1:0];
        else                        step_setting  = data[TI_W-1:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic configure(logic [CFG_W-1:0] count_data, logic [CFG_W-1:0] step_data);
        write_reg(REG_POINT_COUNT, count_data);
        write_reg(REG_T_INCREMENT, step_data);
        settings_used++;
    endtask

    // Hold off new requests until the last expected point has come back
    task automatic wait_idle();
        while (pending_curves.size() != 0 || tx_busy || expected_points.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        int          eff;
        int          r;
        logic [6:0]  cnt;
        logic [CFG_W-1:0] count_data;
        logic [CFG_W-1:0] step_data;

        // Drive every input to a known value and hold reset
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = REG_POINT_COUNT;
        i_cfg_data   = '0;
        crv_if.valid = 1'b0;
        crv_if.p0_x  = '0;
        crv_if.p0_y  = '0;
        crv_if.p0_z  = '0;
        crv_if.p1_x  = '0;
        crv_if.p1_y  = '0;
        crv_if.p1_z  = '0;
        crv_if.p2_x  = '0;
        crv_if.p2_y  = '0;
        crv_if.p2_z  = '0;
        crv_if.p3_x  = '0;
        crv_if.p3_y  = '0;
        crv_if.p3_z  = '0;
        pt_if.ready  = 1'b0;
        count_setting  = PC_RESET;
        step_setting   = TI_RESET;
        gaps_on        = 1'b1;
        stalls_on      = 1'b1;
        hold_req       = 0;
        hold_served    = 0;
        errors         = 0;
        curves_sent    = 0;
        points_checked = 0;
        settings_used  = 1;
        idle_cycles    = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: full-scale corners and an all-zero curve
        queue_curve(make_curve(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF));
        queue_curve(make_curve(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000));
        queue_curve(make_curve(16'h0000, 16'h0000, 16'h0000, 16'h0000));
        wait_idle();

        // Midpoint ties: +0.5 LSB rounds up, -0.5 LSB rounds toward zero
        configure(17'd2, 17'd32768);
        queue_curve(make_curve(16'h0004, 16'h0000, 16'h0000, 16'h0000));
        queue_curve(make_curve(16'hFFFC, 16'h0000, 16'h0000, 16'h0000));
        queue_curve(make_curve(16'h0000, 16'h0000, 16'h0000, 16'hFFFC));
        wait_idle();

        // Zero point count acts as a single point at t = 0
        configure(17'd0, 17'd4096);
        queue_curve(rand_curve());
        queue_curve(make_curve(16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF));
        wait_idle();

        // Oversized count (with junk above bit 6) clamps, largest step saturates
        configure(17'h1FFC1, 17'h1FFFF);
        queue_curve(rand_curve());
        queue_curve(make_curve(16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF));
        wait_idle();

        // Step that lands exactly on t = 1.0 at the last point
        configure(17'd33, 17'd2048);
        queue_curve(rand_curve());
        queue_curve(make_curve(16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF));
        wait_idle();

        // Zero step, then a step of exactly one
        configure(17'd5, 17'd0);
        queue_curve(rand_curve());
        wait_idle();
        configure(17'd3, 17'd65536);
        queue_curve(rand_curve());
        wait_idle();

        // Finest step over a full-length curve
        configure(17'd64, 17'd1);
        queue_curve(make_curve(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF));
        wait_idle();

        // Long receiver hold so the block backs up into its request port
        configure(17'd64, 17'd1040);
        for (int k = 0; k < 4; k++) queue_curve(rand_curve());
        hold_req++;
        wait_idle();

        // Random phases, each with its own settings and idling pattern
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            r = $urandom_range(0, 9);
            if (r < 6)       cnt = 7'($urandom_range(1, 12));
            else if (r < 8)  cnt = 7'($urandom_range(13, 64));
            else if (r == 8) cnt = ($urandom_range(0, 1) != 0) ? 7'd64 : 7'd0;
            else             cnt = 7'($urandom_range(65, 127));
            count_data = {10'd0, cnt};
            if ($urandom_range(0, 1) != 0) count_data[CFG_W-1:PC_W] = 10'($urandom());
            eff = (cnt == 0) ? 1 : ((cnt > 64) ? 64 : int'(cnt));

            r = $urandom_range(0, 9);
            if (r < 4 && eff > 1) step_data = 17'(65536 / (eff - 1) + $urandom_range(0, 3));
            else if (r < 6)       step_data = 17'($urandom_range(0, 131071));
            else if (r < 8)       step_data = 17'($urandom_range(0, 4096));
            else if (r == 8)      step_data = 17'd65536;
            else step_data = ($urandom_range(0, 1) != 0) ? 17'h1FFFF : 17'd0;
            configure(count_data, step_data);

            gaps_on   = (ph == 0) ? 1'b0 : ((ph == 1) ? 1'b1 : ($urandom_range(0, 3) != 0));
            stalls_on = (ph == 0) ? 1'b0 : ((ph == 1) ? 1'b1 : ($urandom_range(0, 3) != 0));
            for (int k = 0; k < PHASE_ITEMS; k++) queue_curve(rand_curve());
            wait_idle();
        end

        $display("Run covered %0d curve requests and %0d checked points across %0d settings",
                 curves_sent, points_checked, settings_used);
        $display("including clamped and zero point counts, saturating steps and a %0d-cycle hold",
                 HOLD_CYCLES);
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
